// ----- hdl/swrtt_pkg.sv -----
// Package: constants and request/response types of the stop-and-wait sender RTT timer.
`default_nettype none

package swrtt_pkg;

   localparam int SEGMENT_BYTES = 512;
   localparam int HEADER_BYTES  = 20;

   localparam int FLEN_W   = 24;
   localparam int MS_W     = 16;
   localparam int SEQ_W    = 16;
   localparam int LEN_W    = 10;
   localparam int TMO_W    = 19;
   localparam int CNT_W    = 32;
   localparam int BYTE_W   = 40;
   localparam int ACKN_W   = 32;
   localparam int FLAG_W   = 8;
   localparam int ACK_BIT  = 4;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_FILE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_RTT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TIMEOUT = 2'd2;

   localparam logic [MS_W-1:0] RESET_INITIAL_RTT = 16'd10;
   localparam logic [MS_W-1:0] RESET_MIN_TIMEOUT = 16'd10;

   typedef struct packed {
      logic              ack_arrived;
      logic [FLAG_W-1:0] ack_flag_bits;
      logic [ACKN_W-1:0] acked_number;
      logic [MS_W-1:0]   rtt_sample_ms;
   } req_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  next_sequence;
      logic [LEN_W-1:0]  next_payload_len;
      logic              resend;
      logic [MS_W-1:0]   smoothed_rtt_ms;
      logic [MS_W-1:0]   rtt_deviation_ms;
      logic [TMO_W-1:0]  timeout_ms;
      logic              transfer_done;
      logic [CNT_W-1:0]  segments_sent;
      logic [CNT_W-1:0]  retransmissions;
      logic [BYTE_W-1:0] byte_total;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/stop_and_wait_sender_rtt_timer_core.sv -----
// Top level: stop-and-wait ARQ sender with smoothed RTT and retransmission timeout.
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   req_data  (req_type)
//   rsp_      out         rsp_valid / rsp_stall   rsp_data  (rsp_type)
//   csr_      in          csr_valid / csr_ready   csr_index, csr_wdata
//
// One request per cycle while req_stall is low; a response is offered after its request is taken
// (input register, then the state update into the response register).
// The sender state is updated in the second stage, as a request moves to the response register.
// Reset is synchronous; it restores register defaults and restarts the sender.
// req_stall rises only when both stages hold data and rsp_stall is high.
// csr_ready is always high; a valid write to index 0, 1 or 2 restarts the sender (index 3 does not).
`default_nettype none

module stop_and_wait_sender_rtt_timer_core
   import swrtt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SEG_W   = $clog2(SEGMENT_BYTES + 1);
   localparam int START_W = SEQ_W + SEG_W;
   localparam int CMP_W   = ((START_W > FLEN_W) ? START_W : FLEN_W) + 1;

   function automatic logic [CMP_W-1:0] seg_start(input logic [SEQ_W-1:0] seq);
      seg_start = CMP_W'(seq) * CMP_W'(SEGMENT_BYTES);
   endfunction

   function automatic logic is_done(input logic [SEQ_W-1:0] seq,
                                    input logic [FLEN_W-1:0] flen);
      is_done = (flen == '0) || (seg_start(seq) > CMP_W'(flen));
   endfunction

   function automatic logic [SEG_W-1:0] pay_len(input logic [SEQ_W-1:0] seq,
                                                input logic [FLEN_W-1:0] flen);
      logic [CMP_W-1:0] start;
      start = seg_start(seq);
      if (is_done(seq, flen)) begin
         pay_len = '0;
      end else if (start + CMP_W'(SEGMENT_BYTES) > CMP_W'(flen)) begin
         pay_len = SEG_W'(CMP_W'(flen) - start);
      end else begin
         pay_len = SEG_W'(SEGMENT_BYTES);
      end
   endfunction

   // configuration
   logic [FLEN_W-1:0] flen_ff, flen_in;
   logic [MS_W-1:0]   init_rtt_ff, init_rtt_in;
   logic [MS_W-1:0]   min_tmo_ff, min_tmo_in;
   logic              restart;

   // sender state
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [MS_W-1:0]   rtt_ff, rtt_in;
   logic [MS_W-1:0]   dev_ff, dev_in;
   logic [TMO_W-1:0]  tmo_ff, tmo_in;
   logic [CNT_W-1:0]  sent_ff, sent_in;
   logic [BYTE_W-1:0] bytes_ff, bytes_in;

   // pipeline
   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_data_ff, s1_data_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_data_ff, out_data_in;
   logic              advance;
   logic              req_take;

   // update datapath
   logic              done_cur;
   logic [SEG_W-1:0]  pay_cur;
   logic              seg_ok;
   logic [TMO_W-1:0]  rtt_sum;
   logic [MS_W-1:0]   rtt_new;
   logic [MS_W-1:0]   diff;
   logic [MS_W+1:0]   dev_sum;
   logic [MS_W-1:0]   dev_new;
   logic [TMO_W-1:0]  tmo_sum;
   logic [BYTE_W:0]   bytes_sum;

   assign csr_ready = 1'b1;
   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      flen_in     = flen_ff;
      init_rtt_in = init_rtt_ff;
      min_tmo_in  = min_tmo_ff;
      restart     = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_FILE_LENGTH: begin
               flen_in = csr_wdata[FLEN_W-1:0];
               restart = 1'b1;
            end
            CSR_INITIAL_RTT: begin
               init_rtt_in = csr_wdata[MS_W-1:0];
               restart     = 1'b1;
            end
            CSR_MIN_TIMEOUT: begin
               min_tmo_in = csr_wdata[MS_W-1:0];
               restart    = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      done_cur  = is_done(seq_ff, flen_ff);
      pay_cur   = pay_len(seq_ff, flen_ff);
      seg_ok    = s1_data_ff.ack_arrived && s1_data_ff.ack_flag_bits[ACK_BIT]
                  && (s1_data_ff.acked_number == ACKN_W'(seq_ff));
      rtt_sum   = (TMO_W'(rtt_ff) << 3) - TMO_W'(rtt_ff) + TMO_W'(s1_data_ff.rtt_sample_ms);
      rtt_new   = rtt_sum[TMO_W-1:3];
      diff      = (s1_data_ff.rtt_sample_ms >= rtt_new) ? s1_data_ff.rtt_sample_ms - rtt_new
                                                        : rtt_new - s1_data_ff.rtt_sample_ms;
      dev_sum   = (MS_W+2)'({dev_ff, 1'b0}) + (MS_W+2)'(dev_ff) + (MS_W+2)'(diff);
      dev_new   = dev_sum[MS_W+1:2];
      tmo_sum   = TMO_W'(rtt_new) + {1'b0, dev_new, 2'b00};
      bytes_sum = {1'b0, bytes_ff} + (BYTE_W+1)'(pay_cur) + (BYTE_W+1)'(HEADER_BYTES);

      seq_in   = seq_ff;
      rtt_in   = rtt_ff;
      dev_in   = dev_ff;
      tmo_in   = tmo_ff;
      sent_in  = sent_ff;
      bytes_in = bytes_ff;

      if (restart) begin
         seq_in   = '0;
         rtt_in   = init_rtt_in;
         dev_in   = '0;
         tmo_in   = TMO_W'((init_rtt_in < min_tmo_in) ? min_tmo_in : init_rtt_in);
         sent_in  = '0;
         bytes_in = '0;
      end else if (advance && !done_cur) begin
         sent_in  = (sent_ff == '1) ? sent_ff : sent_ff + CNT_W'(1);
         bytes_in = bytes_sum[BYTE_W] ? '1 : bytes_sum[BYTE_W-1:0];
         if (seg_ok) begin
            seq_in = (seq_ff == '1) ? seq_ff : seq_ff + SEQ_W'(1);
            rtt_in = rtt_new;
            dev_in = dev_new;
            tmo_in = (tmo_sum < TMO_W'(min_tmo_ff)) ? TMO_W'(min_tmo_ff) : tmo_sum;
         end
      end
   end

   always_comb begin
      out_data_in.next_sequence    = seq_in;
      out_data_in.next_payload_len = LEN_W'(pay_len(seq_in, flen_ff));
      out_data_in.resend           = !done_cur && !seg_ok;
      out_data_in.smoothed_rtt_ms  = rtt_in;
      out_data_in.rtt_deviation_ms = dev_in;
      out_data_in.timeout_ms       = tmo_in;
      out_data_in.transfer_done    = is_done(seq_in, flen_ff);
      out_data_in.segments_sent    = sent_in;
      out_data_in.retransmissions  = (sent_in >= CNT_W'(seq_in)) ? sent_in - CNT_W'(seq_in)
                                                                 : '0;
      out_data_in.byte_total       = bytes_in;

      s1_valid_in  = req_take || (s1_valid_ff && !advance);
      s1_data_in   = req_take ? req_data : s1_data_ff;
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flen_ff      <= '0;
         init_rtt_ff  <= RESET_INITIAL_RTT;
         min_tmo_ff   <= RESET_MIN_TIMEOUT;
         seq_ff       <= '0;
         rtt_ff       <= RESET_INITIAL_RTT;
         dev_ff       <= '0;
         tmo_ff       <= TMO_W'((RESET_INITIAL_RTT < RESET_MIN_TIMEOUT) ? RESET_MIN_TIMEOUT
                                                                         : RESET_INITIAL_RTT);
         sent_ff      <= '0;
         bytes_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         flen_ff      <= flen_in;
         init_rtt_ff  <= init_rtt_in;
         min_tmo_ff   <= min_tmo_in;
         seq_ff       <= seq_in;
         rtt_ff       <= rtt_in;
         dev_ff       <= dev_in;
         tmo_ff       <= tmo_in;
         sent_ff      <= sent_in;
         bytes_ff     <= bytes_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_resend_not_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.resend) |-> !rsp_data.transfer_done)
      else $error("resend reported on a finished transfer");

   a_done_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.transfer_done) |-> (rsp_data.next_payload_len == '0))
      else $error("payload length non-zero after completion");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with a free stage");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

`default_nettype wire
